// ===== sv/shd_pkg.sv =====
// Shared types and constants of the sync-header packet deframer.
package shd_pkg;

	// Field widths of the stream and of the header.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned IDX_W   = 12;
	localparam int unsigned HDRLEN_W = 16;

	// Length field range, and the default build limit on payload length.
	localparam int unsigned FIELD_LEN_CAP     = 4096;
	localparam int unsigned MAX_PAYLOAD_LIMIT_DEF = 4096;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(FIELD_LEN_CAP);

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = LEN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_EMPTY   = 1'b1;

	// Packed result width: type, sequence, length, data byte, index, zero fill.
	localparam int unsigned RES_BITS = BYTE_W + SEQ_W + LEN_W + BYTE_W + IDX_W;
	localparam int unsigned TDATA_W  = ((RES_BITS + 7) / 8) * 8;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_SYNC0   = 3'd0,
		PH_SYNC1   = 3'd1,
		PH_TYPE    = 3'd2,
		PH_SEQ_LO  = 3'd3,
		PH_SEQ_HI  = 3'd4,
		PH_LEN_LO  = 3'd5,
		PH_LEN_HI  = 3'd6,
		PH_PAYLOAD = 3'd7
	} phase_t;

	// Configuration values seen by the parser.
	typedef struct packed {
		logic [BYTE_W-1:0] sync_first;
		logic [BYTE_W-1:0] sync_second;
		logic [LEN_W-1:0]  max_len;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] packet_type;
		logic [SEQ_W-1:0]  sequence_res;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              last;
	} res_t;

endpackage

// ===== sv/shd_cfg_regs.sv =====
// Configuration register file of the deframer.
module shd_cfg_regs import shd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write the addressed register; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= '0;
			cfg_q.sync_second <= '0;
			cfg_q.max_len     <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata[BYTE_W-1:0];
				CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata[BYTE_W-1:0];
				CFG_MAX_LEN:     cfg_q.max_len     <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/shd_parser.sv =====
// Header parser: sync hunt, header capture and payload byte numbering.
module shd_parser import shd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_LIMIT = MAX_PAYLOAD_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              take,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              resync,
	output logic              res_valid,
	output res_t              res
);

	// Length cap from the build limit and from the field range.
	localparam int unsigned LenCap = (MAX_PAYLOAD_LIMIT < FIELD_LEN_CAP) ?
		MAX_PAYLOAD_LIMIT : FIELD_LEN_CAP;
	localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LenCap);

	phase_t             phase_q, phase_d;
	logic [BYTE_W-1:0]  type_q, type_d;
	logic [SEQ_W-1:0]   seq_q, seq_d;
	logic [BYTE_W-1:0]  len_lo_q, len_lo_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   left_q, left_d;

	logic [LEN_W-1:0]    eff_max;
	logic [HDRLEN_W-1:0] hdr_len;
	logic [LEN_W-1:0]    left_dec;
	logic [LEN_W-1:0]    idx_full;
	logic                too_long;
	logic                len_zero;
	logic                final_byte;

	// Header length and payload counting terms.
	assign eff_max    = (cfg.max_len > LenCapV) ? LenCapV : cfg.max_len;
	assign hdr_len    = {in_byte, len_lo_q};
	assign too_long   = hdr_len > {{(HDRLEN_W-LEN_W){1'b0}}, eff_max};
	assign len_zero   = (hdr_len == '0);
	assign left_dec   = left_q - LEN_W'(1);
	assign final_byte = (left_dec == '0);
	assign idx_full   = len_q - left_q;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (resync) begin
			phase_d = PH_SYNC0;
		end else begin
			case (phase_q)
				PH_SYNC0: begin
					if (in_byte == cfg.sync_first) phase_d = PH_SYNC1;
				end
				PH_SYNC1: begin
					if (in_byte == cfg.sync_second) phase_d = PH_TYPE;
					else if (in_byte == cfg.sync_first) phase_d = PH_SYNC1;
					else phase_d = PH_SYNC0;
				end
				PH_TYPE:   phase_d = PH_SEQ_LO;
				PH_SEQ_LO: phase_d = PH_SEQ_HI;
				PH_SEQ_HI: phase_d = PH_LEN_LO;
				PH_LEN_LO: phase_d = PH_LEN_HI;
				PH_LEN_HI: begin
					if (too_long || len_zero) phase_d = PH_SYNC0;
					else phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					if (final_byte) phase_d = PH_SYNC0;
				end
				default: phase_d = PH_SYNC0;
			endcase
		end
	end

	// Held header fields and the result of this byte.
	always_comb begin
		type_d   = type_q;
		seq_d    = seq_q;
		len_lo_d = len_lo_q;
		len_d    = len_q;
		left_d   = left_q;
		res_valid = 1'b0;
		res.kind           = KIND_PAYLOAD;
		res.packet_type    = type_q;
		res.sequence_res   = seq_q;
		res.payload_length = len_q;
		res.data_byte      = in_byte;
		res.byte_index     = idx_full[IDX_W-1:0];
		res.last           = final_byte;
		if (!resync) begin
			case (phase_q)
				PH_TYPE:   type_d = in_byte;
				PH_SEQ_LO: seq_d = {{(SEQ_W-BYTE_W){1'b0}}, in_byte};
				PH_SEQ_HI: seq_d = {in_byte, seq_q[BYTE_W-1:0]};
				PH_LEN_LO: len_lo_d = in_byte;
				PH_LEN_HI: begin
					if (!too_long && len_zero) begin
						res_valid          = 1'b1;
						res.kind           = KIND_EMPTY;
						res.payload_length = '0;
						res.data_byte      = '0;
						res.byte_index     = '0;
						res.last           = 1'b1;
					end else if (!too_long) begin
						len_d  = hdr_len[LEN_W-1:0];
						left_d = hdr_len[LEN_W-1:0];
					end
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					left_d    = left_dec;
				end
				default: ;
			endcase
		end
		// Any return to hunting clears the held header.
		if (phase_d == PH_SYNC0) begin
			type_d   = '0;
			seq_d    = '0;
			len_lo_d = '0;
			len_d    = '0;
			left_d   = '0;
		end
	end

	// Parser state advances on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC0;
			type_q   <= '0;
			seq_q    <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			left_q   <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			seq_q    <= seq_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			left_q   <= left_d;
		end
	end

endmodule

// ===== sv/shd_out_reg.sv =====
// Result register between the parser and the output stream.
module shd_out_reg import shd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_ready,
	output logic out_valid,
	output logic can_load,
	output res_t res_out
);

	logic valid_q;
	res_t res_q;

	// A new result may enter when the register is empty or drains this cycle.
	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

// ===== sv/sync_header_packet_deframer.sv =====
// Sync-header packet deframer: one received byte per input transfer, it hunts for a
// two-byte sync pattern, reads a type byte, a little-endian sequence number and a
// little-endian payload length, then emits one output transfer per payload byte (or
// one empty-packet transfer for a zero length). A byte is taken every cycle while the
// result register is empty or being drained; a result is registered and appears in the
// cycle after the byte that caused it; the only stall source is back-pressure on the
// output. A header longer than max_payload_len (capped at MAX_PAYLOAD_LIMIT and 4096) is
// dropped silently; a transfer with the resync flag set returns the parser to hunting.
module sync_header_packet_deframer import shd_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD_LIMIT = MAX_PAYLOAD_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// Input stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,  // in_byte
	input  logic                  s_axis_tuser,  // resync
	// Output stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// packet_type, sequence_res, payload_length, data_byte, byte_index, zero fill
	output logic [TDATA_W-1:0]    m_axis_tdata,
	output logic                  m_axis_tuser,  // kind
	output logic                  m_axis_tlast   // last
);

	cfg_t cfg;
	logic take;
	logic can_load;
	logic res_valid;
	res_t res;
	res_t res_q;

	assign s_axis_tready = can_load;
	assign take = s_axis_tvalid && can_load;

	shd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	shd_parser #(
		.MAX_PAYLOAD_LIMIT (MAX_PAYLOAD_LIMIT)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.in_byte   (s_axis_tdata),
		.resync    (s_axis_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	shd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && res_valid),
		.res_in    (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.can_load  (can_load),
		.res_out   (res_q)
	);

	// Pack the result fields, lowest field first.
	assign m_axis_tdata = {{(TDATA_W-RES_BITS){1'b0}}, res_q.byte_index, res_q.data_byte,
		res_q.payload_length, res_q.sequence_res, res_q.packet_type};
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tlast = res_q.last;

endmodule
